// File: src/cpd_pkg.sv
// Package for the channel packet deframer: phase codes, result kinds and the result type.
// Used by channel_packet_deframer. Depends on nothing else.
`default_nettype none

package cpd_pkg;

   localparam logic [1:0] PH_CHAN   = 2'd0;
   localparam logic [1:0] PH_LEN_HI = 2'd1;
   localparam logic [1:0] PH_LEN_LO = 2'd2;
   localparam logic [1:0] PH_BODY   = 2'd3;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [15:0] HEADER_BYTES  = 16'd3;
   localparam logic [15:0] TRAILER_BYTES = 16'd2;
   localparam logic [15:0] MIN_LENGTH    = 16'd5;

   localparam logic [7:0] FILE_CHAN_RESET = 8'd2;
   localparam logic [7:0] ASCII_SPACE     = 8'h20;
   localparam logic [7:0] ASCII_ZERO      = 8'h30;
   localparam logic [7:0] ASCII_NINE      = 8'h39;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] status_code;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

// File: src/channel_packet_deframer.sv
// Top level of the channel packet deframer: byte parser, output register and skid stage.
// Depends on cpd_pkg for phase codes, result kinds and the result type.
`default_nettype none

// The deframer takes one stream byte per beat and accepts a byte in every clock cycle while its
// skid stage is not full. Each byte is parsed in the same cycle against the packet state
// registers, and any result it causes is written at the edge that accepts the byte to the
// output register, or to the skid stage if the output is stalled; the result port is driven
// from the output register. A second result register (skid stage) holds one more result while
// the output is stalled. The byte input stalls only while that skid stage is full. Data channel
// payload bytes come out one per beat. A response packet gives one status beat with last set
// after its final trailer byte. A length below five gives one error beat. The data channel
// number may only be written while the block is idle.
module channel_packet_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_status_code,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic [7:0]  file_chan_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  channel_ff, channel_in;
   logic [15:0] packet_length_ff, packet_length_in;
   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] status_accum_ff, status_accum_in;
   logic        status_invalid_ff, status_invalid_in;
   logic        space_seen_ff, space_seen_in;

   logic                  out_valid_ff, out_valid_in;
   cpd_pkg::result_type   out_ff, out_in;
   logic                  skid_valid_ff, skid_valid_in;
   cpd_pkg::result_type   skid_ff, skid_in;

   logic                  req_accept;
   logic                  out_take;
   logic                  res_valid;
   cpd_pkg::result_type   res;
   logic [15:0]           full_length;
   logic                  is_payload;
   logic                  is_end;
   logic                  is_file_chan;
   logic [3:0]            digit;
   logic [19:0]           accum_next;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_take   = out_valid_ff && !rsp_stall;

   assign full_length     = {packet_length_ff[15:8], req_in_byte};
   assign is_payload      = byte_index_ff < (packet_length_ff - cpd_pkg::TRAILER_BYTES);
   assign is_end          = byte_index_ff >= (packet_length_ff - 16'd1);
   assign is_file_chan    = channel_ff == file_chan_ff;
   assign digit           = 4'(req_in_byte - cpd_pkg::ASCII_ZERO);
   assign accum_next      = ({4'd0, status_accum_ff} << 3) + ({4'd0, status_accum_ff} << 1)
                            + {16'd0, digit};

   always_comb begin
      phase_in          = phase_ff;
      channel_in        = channel_ff;
      packet_length_in  = packet_length_ff;
      byte_index_in     = byte_index_ff;
      status_accum_in   = status_accum_ff;
      status_invalid_in = status_invalid_ff;
      space_seen_in     = space_seen_ff;
      res_valid         = 1'b0;
      res               = '0;
      unique case (phase_ff)
         cpd_pkg::PH_CHAN: begin
            channel_in        = req_in_byte;
            packet_length_in  = '0;
            byte_index_in     = 16'd1;
            status_accum_in   = '0;
            status_invalid_in = 1'b0;
            space_seen_in     = 1'b0;
            phase_in          = cpd_pkg::PH_LEN_HI;
         end
         cpd_pkg::PH_LEN_HI: begin
            packet_length_in = {req_in_byte, 8'd0};
            phase_in         = cpd_pkg::PH_LEN_LO;
         end
         cpd_pkg::PH_LEN_LO: begin
            packet_length_in = full_length;
            if (full_length < cpd_pkg::MIN_LENGTH) begin
               phase_in      = cpd_pkg::PH_CHAN;
               byte_index_in = '0;
               res_valid     = 1'b1;
               res.kind      = cpd_pkg::KIND_ERROR;
            end else begin
               byte_index_in = cpd_pkg::HEADER_BYTES;
               phase_in      = cpd_pkg::PH_BODY;
            end
         end
         cpd_pkg::PH_BODY: begin
            byte_index_in = byte_index_ff + 16'd1;
            if (is_payload) begin
               if (is_file_chan) begin
                  res_valid     = 1'b1;
                  res.kind      = cpd_pkg::KIND_DATA;
                  res.data_byte = req_in_byte;
               end else if (!space_seen_ff && !status_invalid_ff) begin
                  priority if (req_in_byte == cpd_pkg::ASCII_SPACE) begin
                     space_seen_in = 1'b1;
                  end else if (req_in_byte < cpd_pkg::ASCII_ZERO ||
                               req_in_byte > cpd_pkg::ASCII_NINE) begin
                     status_invalid_in = 1'b1;
                  end else if (accum_next[19:16] != 4'd0) begin
                     status_invalid_in = 1'b1;
                  end else begin
                     status_accum_in = accum_next[15:0];
                  end
               end
            end else if (is_end) begin
               phase_in      = cpd_pkg::PH_CHAN;
               byte_index_in = '0;
               if (!is_file_chan) begin
                  res_valid       = 1'b1;
                  res.kind        = cpd_pkg::KIND_STATUS;
                  res.status_code = status_invalid_ff ? 16'd0 : status_accum_ff;
                  res.last        = 1'b1;
               end
            end
         end
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept && res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_chan_ff      <= cpd_pkg::FILE_CHAN_RESET;
         phase_ff          <= cpd_pkg::PH_CHAN;
         channel_ff        <= '0;
         packet_length_ff  <= '0;
         byte_index_ff     <= '0;
         status_accum_ff   <= '0;
         status_invalid_ff <= 1'b0;
         space_seen_ff     <= 1'b0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            file_chan_ff <= csr_wr_data;
         end
         if (req_accept) begin
            phase_ff          <= phase_in;
            channel_ff        <= channel_in;
            packet_length_ff  <= packet_length_in;
            byte_index_ff     <= byte_index_in;
            status_accum_ff   <= status_accum_in;
            status_invalid_ff <= status_invalid_in;
            space_seen_ff     <= space_seen_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_data_byte   = out_ff.data_byte;
   assign rsp_status_code = out_ff.status_code;
   assign rsp_last        = out_ff.last;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid stage holds a result while the output register is empty.");

   a_body_length: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == cpd_pkg::PH_BODY) |-> (packet_length_ff >= cpd_pkg::MIN_LENGTH))
      else $error("Packet body entered with a short length.");

   a_body_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == cpd_pkg::PH_BODY) |-> (byte_index_ff < packet_length_ff))
      else $error("Byte index ran past the end of the packet.");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> (skid_valid_ff && $stable(skid_ff)))
      else $error("Skid stage lost or changed a result under stall.");
`endif

endmodule

`default_nettype wire

// File: bench/channel_packet_deframer_tb.sv
// Self-checking testbench for channel_packet_deframer: directed packets, then a random stream.
// Predicts every result beat in step with each accepted byte; depends on cpd_pkg and the RTL.
module channel_packet_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cpd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_status_code;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;

   channel_packet_deframer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_status_code (rsp_status_code),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Deframer state as predicted from the accepted byte stream.
   logic [1:0]  parse_phase   = PH_CHAN;
   logic [7:0]  parse_channel = 8'h00;
   logic [15:0] parse_length  = 16'h0000;
   logic [15:0] parse_index   = 16'h0000;
   logic [15:0] status_value  = 16'h0000;
   logic        status_bad    = 1'b0;
   logic        status_done   = 1'b0;
   logic [7:0]  file_chan     = FILE_CHAN_RESET;

   result_type  expected_beats[$];
   result_type  oldest_beat;
   logic [7:0]  body_q[$];
   logic [7:0]  frame_q[$];

   int error_count = 0;
   int beats_sent = 0;
   int burst_left = 0;
   int channel_writes = 0;
   int data_seen = 0;
   int status_seen = 0;
   int errors_seen = 0;
   int stall_mode = 0;
   int stall_timer = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 50) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] value);
      logic [15:0] pos;
      logic [19:0] next_value;
      result_type  beat;
      beat = '0;
      case (parse_phase)
         PH_LEN_HI: begin
            parse_length = {value, 8'h00};
            parse_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            parse_length = parse_length | {8'h00, value};
            if (parse_length < MIN_LENGTH) begin
               parse_phase = PH_CHAN;
               parse_index = 16'h0000;
               beat.kind = KIND_ERROR;
               expected_beats.push_back(beat);
            end else begin
               parse_index = HEADER_BYTES;
               parse_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            pos = parse_index;
            parse_index = parse_index + 16'd1;
            if (pos < parse_length - TRAILER_BYTES) begin
               if (parse_channel == file_chan) begin
                  beat.kind = KIND_DATA;
                  beat.data_byte = value;
                  expected_beats.push_back(beat);
               end else if (!status_done && !status_bad) begin
                  if (value == ASCII_SPACE) begin
                     status_done = 1'b1;
                  end else if (value < ASCII_ZERO || value > ASCII_NINE) begin
                     status_bad = 1'b1;
                  end else begin
                     next_value = status_value * 20'd10 + 20'(value - ASCII_ZERO);
                     if (next_value > 20'h0FFFF) begin
                        status_bad = 1'b1;
                     end else begin
                        status_value = next_value[15:0];
                     end
                  end
               end
            end else if ({1'b0, pos} + 17'd1 >= {1'b0, parse_length}) begin
               parse_phase = PH_CHAN;
               parse_index = 16'h0000;
               if (parse_channel != file_chan) begin
                  beat.kind = KIND_STATUS;
                  beat.status_code = status_bad ? 16'h0000 : status_value;
                  beat.last = 1'b1;
                  expected_beats.push_back(beat);
               end
            end
         end
         default: begin
            parse_channel = value;
            parse_length = 16'h0000;
            parse_index = 16'd1;
            status_value = 16'h0000;
            status_bad = 1'b0;
            status_done = 1'b0;
            parse_phase = PH_LEN_HI;
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (req_stall);
      deframe_byte(value);
      beats_sent++;
   endtask

   task automatic build_frame(input logic [7:0] chan, input logic [15:0] len);
      int n;
      frame_q.delete();
      frame_q.push_back(chan);
      frame_q.push_back(len[15:8]);
      frame_q.push_back(len[7:0]);
      if (len >= MIN_LENGTH) begin
         for (n = 0; n < int'(len) - int'(MIN_LENGTH); n++) begin
            frame_q.push_back(body_q.size() != 0 ? body_q.pop_front() : 8'($urandom));
         end
         repeat (int'(TRAILER_BYTES)) frame_q.push_back(8'($urandom));
      end
      body_q.delete();
   endtask

   task automatic send_frame(input int count);
      int n;
      for (n = 0; n < count && n < frame_q.size(); n++) begin
         send_byte(frame_q[n]);
      end
   endtask

   task automatic send_packet(input logic [7:0] chan, input logic [15:0] len);
      build_frame(chan, len);
      send_frame(frame_q.size());
   endtask

   task automatic send_text(input logic [7:0] chan, input string text);
      int i;
      for (i = 0; i < text.len(); i++) begin
         body_q.push_back(text[i]);
      end
      send_packet(chan, 16'(body_q.size()) + MIN_LENGTH);
   endtask

   task automatic resync();
      while (parse_phase != PH_CHAN) begin
         send_byte(parse_phase == PH_LEN_HI ? 8'($urandom_range(0, 1)) : 8'($urandom));
      end
   endtask

   task automatic wait_idle();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (expected_beats.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_beats.size() != 0) begin
         report_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));
         expected_beats.delete();
      end
      repeat (8) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_file_chan(input logic [7:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      file_chan = value;
      channel_writes++;
   endtask

   task automatic load_status_text();
      int digits;
      int i;
      digits = $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) begin
         body_q.push_back(8'($urandom));
      end
      for (i = 0; i < digits; i++) begin
         body_q.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 3) != 0) begin
         body_q.push_back(ASCII_SPACE);
         repeat ($urandom_range(0, 8)) body_q.push_back(8'($urandom_range(32, 126)));
      end
   endtask

   task automatic test_data_passthrough();
      body_q = '{8'h00, 8'hFF, 8'h0D, 8'h0A, ASCII_ZERO, ASCII_ZERO};
      send_packet(FILE_CHAN_RESET, 16'd11);
      send_packet(FILE_CHAN_RESET, MIN_LENGTH);
   endtask

   task automatic test_status_parsing();
      send_text(8'h00, "65535 A");
      send_text(8'hFF, "65536 B");
      send_text(8'h00, "4x2 ");
      send_text(8'h01, " 77");
      send_text(8'h00, "123");
      send_text(8'h00, "00099 9x");
      send_packet(8'hFF, MIN_LENGTH);
   endtask

   task automatic test_short_length();
      send_packet(8'h07, 16'd0);
      send_packet(8'hFF, 16'd4);
      send_text(8'h00, "1 ");
   endtask

   task automatic test_channel_select();
      write_file_chan(8'h00);
      send_text(FILE_CHAN_RESET, "3 x");
      send_text(8'h00, "AB");
      write_file_chan(8'hFF);
      send_text(8'hFF, "Z9");
      send_text(8'h00, "501");
   endtask

   task automatic test_random_stream(input int item_count);
      int stop_at;
      int next_write_at;
      int pick;
      logic [7:0] chan;
      logic [15:0] len;
      stop_at = beats_sent + item_count;
      next_write_at = beats_sent + $urandom_range(80, 200);
      while (beats_sent < stop_at) begin
         if (beats_sent >= next_write_at) begin
            pick = $urandom_range(0, 3);
            write_file_chan(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom));
            next_write_at = beats_sent + $urandom_range(80, 200);
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            if ($urandom_range(0, 39) == 0) begin
               len = 16'($urandom_range(256, 300));
            end else begin
               len = 16'($urandom_range(5, 24));
            end
            send_packet(file_chan, len);
         end else if (pick < 70) begin
            chan = 8'($urandom);
            load_status_text();
            if ($urandom_range(0, 9) == 0) begin
               len = 16'($urandom_range(5, 20));
            end else begin
               len = 16'(body_q.size()) + MIN_LENGTH;
            end
            send_packet(chan, len);
         end else if (pick < 80) begin
            send_packet(8'($urandom), 16'($urandom_range(0, 4)));
         end else if (pick < 90) begin
            build_frame(8'($urandom), 16'($urandom_range(5, 30)));
            send_frame($urandom_range(1, frame_q.size() - 1));
            resync();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_byte(parse_phase == PH_LEN_HI ? 8'($urandom_range(0, 1)) : 8'($urandom));
            end
            resync();
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode = $urandom_range(0, 4);
         stall_timer = $urandom_range(16, 96);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         3: rsp_stall <= ~rsp_stall;
         default: rsp_stall <= (stall_timer % 16 < 12);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat: kind %0d data %02h status %0d last %0b",
                                      rsp_kind, rsp_data_byte, rsp_status_code, rsp_last));
         end else begin
            oldest_beat = expected_beats.pop_front();
            if (rsp_kind !== oldest_beat.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, oldest_beat.kind));
            if (rsp_data_byte !== oldest_beat.data_byte)
               report_mismatch($sformatf("data_byte %02h, expected %02h",
                                         rsp_data_byte, oldest_beat.data_byte));
            if (rsp_status_code !== oldest_beat.status_code)
               report_mismatch($sformatf("status_code %0d, expected %0d",
                                         rsp_status_code, oldest_beat.status_code));
            if (rsp_last !== oldest_beat.last)
               report_mismatch($sformatf("last %0b, expected %0b", rsp_last, oldest_beat.last));
            case (oldest_beat.kind)
               KIND_DATA:   data_seen++;
               KIND_STATUS: status_seen++;
               default:     errors_seen++;
            endcase
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_data_passthrough();
      test_status_parsing();
      test_short_length();
      test_channel_select();
      test_random_stream(970);
      wait_idle();
      repeat (20) @(posedge clock);
      $display("Streamed %0d bytes across %0d data channel writes, including 0 and 255.",
               beats_sent, channel_writes);
      $display("Checked %0d data beats, %0d status beats and %0d length error beats.",
               data_seen, status_seen, errors_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timed out waiting for the deframer.");
      $display("Test completed with failures");
      $finish;
   end

endmodule
